// ===== hdl/nts_pkg.sv =====
// Shared types and constants for the note tracker with sustain pedal.
// No dependencies; every module in hdl/ imports this package.
package nts_pkg;

  // default sizing of the key maps and the voice limit
  localparam int KEY_COUNT_DEF  = 128;
  localparam int MAX_VOICES_DEF = 16;

  // reset value of the note limit register
  localparam logic [4:0] NOTE_LIMIT_RST = 5'd16;

  // event codes carried in the func field
  typedef enum logic [1:0] {
    FN_NOTE_ON  = 2'd0,
    FN_NOTE_OFF = 2'd1,
    FN_PEDAL    = 2'd2,
    FN_ALL_OFF  = 2'd3
  } func_t;

  // one input request
  typedef struct packed {
    logic [1:0] func;
    logic [7:0] key;
    logic [6:0] velocity;
    logic       pedal_down;
  } in_item_t;

  // one result word
  typedef struct packed {
    logic        start_valid;
    logic [6:0]  start_key;
    logic [6:0]  start_velocity;
    logic        stop_valid;
    logic [6:0]  stop_key;
    logic [63:0] release_low;
    logic [63:0] release_high;
    logic [4:0]  voices_active;
  } out_item_t;

endpackage

// ===== hdl/nts_in_if.sv =====
// Input channel of the note tracker: valid/ready handshake plus event fields.
// Stand-alone interface, no dependencies.
interface nts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] key;
  logic [6:0] velocity;
  logic       pedal_down;

  modport source (output valid, func, key, velocity, pedal_down, input ready);
  modport sink   (input valid, func, key, velocity, pedal_down, output ready);
endinterface

// ===== hdl/nts_out_if.sv =====
// Result channel of the note tracker: valid/ready handshake plus command word.
// Stand-alone interface, no dependencies.
interface nts_out_if;
  logic        valid;
  logic        ready;
  logic        start_valid;
  logic [6:0]  start_key;
  logic [6:0]  start_velocity;
  logic        stop_valid;
  logic [6:0]  stop_key;
  logic [63:0] release_low;
  logic [63:0] release_high;
  logic [4:0]  voices_active;

  modport source (output valid, start_valid, start_key, start_velocity, stop_valid,
                  stop_key, release_low, release_high, voices_active, input ready);
  modport sink   (input valid, start_valid, start_key, start_velocity, stop_valid,
                  stop_key, release_low, release_high, voices_active, output ready);
endinterface

// ===== hdl/nts_in_reg.sv =====
// Input register stage: captures one request from the input channel.
// Depends on nts_pkg and nts_in_if.
module nts_in_reg (
  input  logic             clk,
  input  logic             rst_n,
  nts_in_if.sink           in_ch,
  input  logic             adv,
  output logic             vld,
  output nts_pkg::in_item_t item
);
  import nts_pkg::*;

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     take;

  // stage is free when empty or draining this cycle
  assign in_ch.ready = !vld_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    if (take) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{func: in_ch.func, key: in_ch.key, velocity: in_ch.velocity,
                  pedal_down: in_ch.pedal_down};
    end
  end

  assign vld  = vld_r;
  assign item = item_r;
endmodule

// ===== hdl/nts_core.sv =====
// Tracker state (held map, sustain map, pedal, counts, note limit) and the
// single-pass update that turns one request into one result word.
// Depends on nts_pkg.
module nts_core #(
  parameter int KEY_COUNT  = nts_pkg::KEY_COUNT_DEF,
  parameter int MAX_VOICES = nts_pkg::MAX_VOICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               fire,
  input  nts_pkg::in_item_t  item,
  output nts_pkg::out_item_t res
);
  import nts_pkg::*;

  localparam int         KW        = $clog2(KEY_COUNT);
  localparam logic [8:0] KEY_LIMIT = 9'(KEY_COUNT);
  localparam logic [6:0] VOICE_MAX = 7'(MAX_VOICES);

  logic [KEY_COUNT-1:0] held_r, held_nxt;
  logic [KEY_COUNT-1:0] sus_r, sus_nxt;
  logic                 ped_r, ped_nxt;
  logic [4:0]           cnt_r, cnt_nxt;
  // number of keys that are both held and sustained
  logic [4:0]           both_r, both_nxt;
  logic [4:0]           limit_r;

  func_t                fn;
  logic [KW-1:0]        k;
  logic                 key_ok, hk, sk;
  logic [6:0]           lim;
  logic                 at_limit;
  logic [KEY_COUNT-1:0] steal_oh;
  logic [KW-1:0]        steal_idx;
  logic                 steal_sus;
  logic [KEY_COUNT-1:0] rel_src;
  logic [127:0]         rel_wide;
  logic                 start_v, stop_v;
  logic [6:0]           stop_k;

  assign fn     = func_t'(item.func);
  assign k      = item.key[KW-1:0];
  assign key_ok = {1'b0, item.key} < KEY_LIMIT;
  assign hk     = held_r[k];
  assign sk     = sus_r[k];

  // effective voice limit, clamped into 1..MAX_VOICES
  always_comb begin
    lim = (limit_r == 5'd0) ? 7'd1 : {2'b00, limit_r};
    if (lim > VOICE_MAX) begin
      lim = VOICE_MAX;
    end
  end
  assign at_limit = {2'b00, cnt_r} >= lim;

  // lowest held key: isolate lowest set bit, then encode it
  assign steal_oh  = held_r & (~held_r + KEY_COUNT'(1));
  assign steal_sus = |(steal_oh & sus_r);
  always_comb begin
    steal_idx = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (steal_oh[i]) begin
        steal_idx = steal_idx | KW'(i);
      end
    end
  end

  // next state and command fields
  always_comb begin
    held_nxt = held_r;
    sus_nxt  = sus_r;
    ped_nxt  = ped_r;
    cnt_nxt  = cnt_r;
    both_nxt = both_r;
    rel_src  = '0;
    start_v  = 1'b0;
    stop_v   = 1'b0;
    stop_k   = '0;
    unique case (fn)
      FN_NOTE_ON: begin
        if (key_ok && !hk) begin
          if (at_limit) begin
            held_nxt = held_nxt & ~steal_oh;
            stop_v   = 1'b1;
            stop_k   = 7'(steal_idx);
            both_nxt = both_r - 5'(steal_sus) + 5'(sk);
          end else begin
            cnt_nxt  = cnt_r + 5'd1;
            both_nxt = both_r + 5'(sk);
          end
          held_nxt[k] = 1'b1;
          start_v     = 1'b1;
        end
      end
      FN_NOTE_OFF: begin
        if (key_ok) begin
          if (ped_r && hk) begin
            // key goes to the sustained set only
            sus_nxt[k] = 1'b1;
            both_nxt   = both_r + 5'(!sk);
          end else begin
            stop_v = 1'b1;
            stop_k = item.key[6:0];
            if (hk) begin
              held_nxt[k] = 1'b0;
              cnt_nxt     = cnt_r - 5'd1;
              both_nxt    = both_r - 5'(sk);
            end
          end
        end
      end
      FN_PEDAL: begin
        if (item.pedal_down != ped_r) begin
          ped_nxt = item.pedal_down;
          if (!item.pedal_down) begin
            // pedal up releases the sustained set
            rel_src  = sus_r;
            held_nxt = held_r & ~sus_r;
            sus_nxt  = '0;
            cnt_nxt  = cnt_r - both_r;
            both_nxt = '0;
          end
        end
      end
      FN_ALL_OFF: begin
        ped_nxt  = 1'b0;
        sus_nxt  = '0;
        rel_src  = held_r;
        held_nxt = '0;
        cnt_nxt  = '0;
        both_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // widen release mask to the full 128-key range
  for (genvar g = 0; g < 128; g++) begin : g_rel
    if (g < KEY_COUNT) begin : g_key
      assign rel_wide[g] = rel_src[g];
    end else begin : g_pad
      assign rel_wide[g] = 1'b0;
    end
  end

  // result word
  always_comb begin
    res                = '0;
    res.start_valid    = start_v;
    res.start_key      = start_v ? item.key[6:0] : 7'd0;
    res.start_velocity = start_v ? item.velocity : 7'd0;
    res.stop_valid     = stop_v;
    res.stop_key       = stop_k;
    res.release_low    = rel_wide[63:0];
    res.release_high   = rel_wide[127:64];
    res.voices_active  = cnt_nxt;
  end

  // tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      sus_r  <= '0;
      ped_r  <= 1'b0;
      cnt_r  <= '0;
      both_r <= '0;
    end else if (fire) begin
      held_r <= held_nxt;
      sus_r  <= sus_nxt;
      ped_r  <= ped_nxt;
      cnt_r  <= cnt_nxt;
      both_r <= both_nxt;
    end
  end

  // note limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= NOTE_LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end
endmodule

// ===== hdl/nts_out_reg.sv =====
// Result register stage: holds one result word for the output channel.
// Depends on nts_pkg and nts_out_if.
module nts_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               src_vld,
  input  nts_pkg::out_item_t res,
  output logic               adv,
  nts_out_if.source          out_ch
);
  import nts_pkg::*;

  logic      vld_r, vld_nxt;
  out_item_t res_r;
  logic      load;

  // free when empty or being taken now
  assign adv  = !vld_r || out_ch.ready;
  assign load = src_vld && adv;

  always_comb begin
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end else begin
      vld_nxt = vld_r;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.start_valid    = res_r.start_valid;
  assign out_ch.start_key      = res_r.start_key;
  assign out_ch.start_velocity = res_r.start_velocity;
  assign out_ch.stop_valid     = res_r.stop_valid;
  assign out_ch.stop_key       = res_r.stop_key;
  assign out_ch.release_low    = res_r.release_low;
  assign out_ch.release_high   = res_r.release_high;
  assign out_ch.voices_active  = res_r.voices_active;
endmodule

// ===== hdl/note_tracker_with_sustain.sv =====
// Note tracker with sustain pedal. Every accepted request (note on, note off,
// pedal change, all notes off) yields exactly one command word: a voice to
// start, a single key to stop (stolen or let go, handled before the start) and
// a 128-key release mask, plus the held-key count. One request per clock is
// sustained while results are taken; each result passes the input register,
// then one pass of map update and lowest-key encode into the result register.
// Result-side backpressure stalls the input side only when both registers are
// full. No initialization time after reset. The user must write note_limit
// via cfg_we/cfg_wdata while no request is in flight; nothing enforces this.
// Depends on nts_pkg, nts_in_if, nts_out_if, nts_in_reg, nts_core, nts_out_reg.
module note_tracker_with_sustain #(
  parameter int KEY_COUNT  = nts_pkg::KEY_COUNT_DEF,
  parameter int MAX_VOICES = nts_pkg::MAX_VOICES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  nts_in_if.sink     in_req,
  nts_out_if.source  out_res,
  input  logic       cfg_we,
  input  logic [4:0] cfg_wdata
);
  import nts_pkg::*;

  logic      s1_vld;
  in_item_t  s1_item;
  logic      adv;
  out_item_t res;

  // input register
  nts_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_req),
    .adv   (adv),
    .vld   (s1_vld),
    .item  (s1_item)
  );

  // tracker state and update
  nts_core #(
    .KEY_COUNT  (KEY_COUNT),
    .MAX_VOICES (MAX_VOICES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (s1_vld && adv),
    .item      (s1_item),
    .res       (res)
  );

  // result register
  nts_out_reg u_out_reg (
    .clk     (clk),
    .rst_n   (rst_n),
    .src_vld (s1_vld),
    .res     (res),
    .adv     (adv),
    .out_ch  (out_res)
  );

  // a start never comes with a bulk release
  a_start_no_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.start_valid |->
      out_res.release_low == 64'd0 && out_res.release_high == 64'd0)
    else $error("start issued together with a release mask");

  // a stolen key is never the key being started
  a_steal_other_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.start_valid && out_res.stop_valid |->
      out_res.stop_key != out_res.start_key)
    else $error("stolen key equals started key");

  // held count stays within the voice limit range
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid |-> {2'b00, out_res.voices_active} <= 7'(MAX_VOICES))
    else $error("voice count above maximum");
endmodule

// ===== tb/note_tracker_with_sustain_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for note_tracker_with_sustain: directed and random
// note, pedal and all-off requests against an in-bench key tracker model.
// Depends on nts_pkg, nts_in_if, nts_out_if and the note_tracker_with_sustain RTL.
module note_tracker_with_sustain_test;
  import nts_pkg::*;

  localparam int MAX_VOICES     = MAX_VOICES_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 300;
  localparam int REPORT_MAX     = 10;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [4:0] cfg_wdata;

  nts_in_if  in_ch ();
  nts_out_if out_ch ();

  note_tracker_with_sustain u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_ch),
    .out_res   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // tracker model state
  logic [127:0] held_keys;
  logic [127:0] sustained_keys;
  logic         pedal_is_down;
  int           held_count;
  logic [4:0]   limit_reg;

  // commands predicted but not yet seen
  out_item_t pending_cmds[$];

  // run bookkeeping
  int  fail_cnt;
  int  sent_cnt;
  int  seen_cnt;
  int  limit_writes;
  int  hold_cycles;
  bit  in_gaps_on;
  bit  out_gaps_on;
  int  idle_cycles;
  out_item_t seen_cmd;
  out_item_t want_cmd;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // expected command word for one request, updating the model state
  function automatic out_item_t track_event(in_item_t ev);
    out_item_t    r;
    int           lim;
    int           drop;
    bit           found;
    logic [6:0]   k;
    r     = '0;
    k     = ev.key[6:0];
    found = 1'b0;
    if (limit_reg == 5'd0) lim = 1;
    else if (int'(limit_reg) > MAX_VOICES) lim = MAX_VOICES;
    else lim = int'(limit_reg);
    case (ev.func)
      FN_NOTE_ON: begin
        if (!ev.key[7] && !held_keys[k]) begin
          // at the limit the lowest held key is stolen first
          if (held_count >= lim) begin
            for (int n = 0; n < 128; n++) begin
              if (!found && held_keys[n]) begin
                found        = 1'b1;
                held_keys[n] = 1'b0;
                if (held_count > 0) held_count--;
                r.stop_valid = 1'b1;
                r.stop_key   = n[6:0];
              end
            end
          end
          held_keys[k]     = 1'b1;
          held_count++;
          r.start_valid    = 1'b1;
          r.start_key      = k;
          r.start_velocity = ev.velocity;
        end
      end
      FN_NOTE_OFF: begin
        if (!ev.key[7]) begin
          if (pedal_is_down && held_keys[k]) begin
            sustained_keys[k] = 1'b1;
          end else begin
            r.stop_valid = 1'b1;
            r.stop_key   = k;
            if (held_keys[k]) begin
              held_keys[k] = 1'b0;
              if (held_count > 0) held_count--;
            end
          end
        end
      end
      FN_PEDAL: begin
        if (ev.pedal_down != pedal_is_down) begin
          pedal_is_down = ev.pedal_down;
          // pedal up lets the whole sustained set go as a mask
          if (!ev.pedal_down) begin
            drop           = $countones(held_keys & sustained_keys);
            r.release_low  = sustained_keys[63:0];
            r.release_high = sustained_keys[127:64];
            held_keys      = held_keys & ~sustained_keys;
            sustained_keys = '0;
            held_count     = (drop > held_count) ? 0 : held_count - drop;
          end
        end
      end
      default: begin
        pedal_is_down  = 1'b0;
        sustained_keys = '0;
        r.release_low  = held_keys[63:0];
        r.release_high = held_keys[127:64];
        held_keys      = '0;
        held_count     = 0;
      end
    endcase
    r.voices_active = held_count[4:0];
    return r;
  endfunction

  function automatic in_item_t make_event(func_t f, int k, int v, bit p);
    in_item_t ev;
    ev.func       = f;
    ev.key        = k[7:0];
    ev.velocity   = v[6:0];
    ev.pedal_down = p;
    return ev;
  endfunction

  // random request, mostly notes around a window so offs hit held keys
  function automatic in_item_t random_event(int key_base);
    in_item_t ev;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 42) ev.func = FN_NOTE_ON;
    else if (pick < 78) ev.func = FN_NOTE_OFF;
    else if (pick < 95) ev.func = FN_PEDAL;
    else ev.func = FN_ALL_OFF;
    pick = $urandom_range(0, 99);
    if (pick < 60) ev.key = 8'(key_base + int'($urandom_range(0, 23)));
    else if (pick < 92) ev.key = 8'($urandom_range(0, 127));
    else ev.key = 8'($urandom_range(128, 255));
    ev.velocity   = 7'($urandom_range(0, 127));
    ev.pedal_down = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // offer one request and wait until it is taken
  task automatic send_event(input in_item_t ev);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.func       <= ev.func;
    in_ch.key        <= ev.key;
    in_ch.velocity   <= ev.velocity;
    in_ch.pedal_down <= ev.pedal_down;
    in_ch.valid      <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_cmds.push_back(track_event(ev));
    sent_cnt++;
  endtask

  // stop offering and wait for every command to come back
  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // note limit is only written while the block is idle
  task automatic write_note_limit(input logic [4:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_reg = value;
    limit_writes++;
  endtask

  task automatic report_failure(input string what);
    fail_cnt++;
    if (fail_cnt <= REPORT_MAX) begin
      $display("[%0t] %s", $time, what);
      $display("  expected: start %0b/%0d/%0d stop %0b/%0d rel %h_%h voices %0d",
               want_cmd.start_valid, want_cmd.start_key, want_cmd.start_velocity,
               want_cmd.stop_valid, want_cmd.stop_key, want_cmd.release_high,
               want_cmd.release_low, want_cmd.voices_active);
      $display("  actual:   start %0b/%0d/%0d stop %0b/%0d rel %h_%h voices %0d",
               seen_cmd.start_valid, seen_cmd.start_key, seen_cmd.start_velocity,
               seen_cmd.stop_valid, seen_cmd.stop_key, seen_cmd.release_high,
               seen_cmd.release_low, seen_cmd.voices_active);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_cmd.start_valid    = out_ch.start_valid;
      seen_cmd.start_key      = out_ch.start_key;
      seen_cmd.start_velocity = out_ch.start_velocity;
      seen_cmd.stop_valid     = out_ch.stop_valid;
      seen_cmd.stop_key       = out_ch.stop_key;
      seen_cmd.release_low    = out_ch.release_low;
      seen_cmd.release_high   = out_ch.release_high;
      seen_cmd.voices_active  = out_ch.voices_active;
      seen_cnt++;
      if (pending_cmds.size() == 0) begin
        want_cmd = '0;
        report_failure("command word with no request pending");
      end else begin
        want_cmd = pending_cmds.pop_front();
        if (seen_cmd.start_valid !== want_cmd.start_valid ||
            seen_cmd.start_key !== want_cmd.start_key ||
            seen_cmd.start_velocity !== want_cmd.start_velocity ||
            seen_cmd.stop_valid !== want_cmd.stop_valid ||
            seen_cmd.stop_key !== want_cmd.stop_key ||
            seen_cmd.release_low !== want_cmd.release_low ||
            seen_cmd.release_high !== want_cmd.release_high ||
            seen_cmd.voices_active !== want_cmd.voices_active) begin
          report_failure("command word mismatch");
        end
      end
    end
  end

  // result side ready, with random stalls and one long hold-off
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = out_gaps_on ? $urandom_range(0, 16) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // watchdog on cycles where no request moves
  initial begin
    idle_cycles = 0;
    wait (rst_n === 1'b1);
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // edges of every field, repeats, ignored keys and the pedal paths
  task automatic test_directed_events;
    send_event(make_event(FN_NOTE_ON, 0, 127, 1'b0));
    send_event(make_event(FN_NOTE_ON, 127, 0, 1'b1));
    send_event(make_event(FN_NOTE_ON, 0, 55, 1'b0));
    send_event(make_event(FN_NOTE_ON, 200, 99, 1'b0));
    send_event(make_event(FN_NOTE_OFF, 255, 0, 1'b1));
    send_event(make_event(FN_NOTE_OFF, 5, 17, 1'b0));
    send_event(make_event(FN_PEDAL, 0, 0, 1'b1));
    send_event(make_event(FN_PEDAL, 3, 0, 1'b1));
    send_event(make_event(FN_NOTE_OFF, 0, 0, 1'b0));
    send_event(make_event(FN_NOTE_OFF, 9, 0, 1'b0));
    send_event(make_event(FN_PEDAL, 0, 0, 1'b0));
    send_event(make_event(FN_PEDAL, 0, 0, 1'b0));
    send_event(make_event(FN_NOTE_ON, 64, 1, 1'b0));
    send_event(make_event(FN_ALL_OFF, 128, 127, 1'b1));
  endtask

  // stealing at a low limit, including a stolen key that was sustained
  task automatic test_voice_stealing;
    write_note_limit(5'd2);
    send_event(make_event(FN_NOTE_ON, 10, 40, 1'b0));
    send_event(make_event(FN_NOTE_ON, 20, 50, 1'b0));
    send_event(make_event(FN_NOTE_ON, 30, 60, 1'b0));
    send_event(make_event(FN_PEDAL, 0, 0, 1'b1));
    send_event(make_event(FN_NOTE_OFF, 20, 0, 1'b0));
    send_event(make_event(FN_NOTE_ON, 40, 70, 1'b0));
    send_event(make_event(FN_PEDAL, 0, 0, 1'b0));
    send_event(make_event(FN_ALL_OFF, 0, 0, 1'b0));
    // zero saturates to a limit of one
    write_note_limit(5'd0);
    send_event(make_event(FN_NOTE_ON, 1, 10, 1'b0));
    send_event(make_event(FN_NOTE_ON, 2, 20, 1'b0));
  endtask

  // random requests under a range of note limits
  task automatic test_random_phases;
    logic [4:0] limits [6];
    limits = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd5, 5'd3};
    limits[5] = 5'($urandom_range(1, 16));
    foreach (limits[i]) begin
      int key_base;
      key_base = $urandom_range(0, 104);
      write_note_limit(limits[i]);
      repeat (75) send_event(random_event(key_base));
    end
  endtask

  // a stretch with no idling on either side
  task automatic test_back_to_back;
    int key_base;
    key_base = $urandom_range(0, 104);
    write_note_limit(5'd4);
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    repeat (60) send_event(random_event(key_base));
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
  endtask

  // result side holds off while requests keep coming, filling the block
  task automatic test_result_backpressure;
    int key_base;
    key_base = $urandom_range(0, 104);
    write_note_limit(5'd8);
    hold_cycles = LONG_HOLD;
    in_gaps_on  = 1'b0;
    repeat (40) send_event(random_event(key_base));
    in_gaps_on  = 1'b1;
  endtask

  // main sequence
  initial begin
    held_keys      = '0;
    sustained_keys = '0;
    pedal_is_down  = 1'b0;
    held_count     = 0;
    limit_reg      = NOTE_LIMIT_RST;
    fail_cnt       = 0;
    sent_cnt       = 0;
    seen_cnt       = 0;
    limit_writes   = 0;
    hold_cycles    = 0;
    in_gaps_on     = 1'b1;
    out_gaps_on    = 1'b1;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= 5'd0;
    in_ch.valid      <= 1'b0;
    in_ch.func       <= FN_NOTE_ON;
    in_ch.key        <= 8'd0;
    in_ch.velocity   <= 7'd0;
    in_ch.pedal_down <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_events();
    test_voice_stealing();
    test_random_phases();
    test_back_to_back();
    test_result_backpressure();

    drain();
    repeat (8) @(posedge clk);
    fail_cnt += pending_cmds.size();

    $display("ran %0d requests and checked %0d command words over %0d note limit writes",
             sent_cnt, seen_cnt, limit_writes);
    $display("covered stealing, sustain, pedal release masks, all-off and a %0d-cycle stall",
             LONG_HOLD);
    if (fail_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_cnt);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nts_pkg.sv
hdl/nts_in_if.sv
hdl/nts_out_if.sv
hdl/nts_in_reg.sv
hdl/nts_core.sv
hdl/nts_out_reg.sv
hdl/note_tracker_with_sustain.sv
tb/note_tracker_with_sustain_test.sv
